[src/rgbcct_pkg.sv]
// rgbcct_pkg: shared types and constants for the rgb to color temperature pipeline
`timescale 1ns / 1ps
`default_nettype none
package rgbcct_pkg;

  localparam int unsigned ChanW = 16;
  localparam int unsigned NClamp = 8;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [ChanW-1:0] color_temp;
    logic [ChanW-1:0] illuminance;
    logic             undefined_flag;
    logic             clamped_flag;
  } cct_t;

endpackage
`default_nettype wire

[src/rgbcct_if.sv]
// rgbcct_if: valid/ready stream interface carrying one payload per beat
`timescale 1ns / 1ps
`default_nettype none
interface rgbcct_if #(
  parameter int unsigned PayloadW = 48
);
  logic                valid;
  logic                ready;
  logic [PayloadW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/rgbcct_div.sv]
// rgbcct_div: pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module rgbcct_div #(
  parameter int unsigned NumW = 56,
  parameter int unsigned QW   = 20,
  parameter int unsigned TagW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [NumW-1:0] den_i,
  input  wire logic [TagW-1:0] tag_i,
  output logic                 valid_o,
  output logic [QW-1:0]        quo_o,
  output logic [TagW-1:0]      tag_o
);
  // partial remainder stays below den, so NumW+1 bits suffice
  // quotient must fit in QW bits, so the top bits of num preload the remainder
  logic [QW:0]              vld_q;
  logic [QW:0][NumW:0]      rem_q;
  logic [QW:0][NumW-1:0]    den_q;
  logic [QW:0][QW-1:0]      quo_q;
  logic [QW:0][TagW-1:0]    tag_q;
  logic [QW:0][NumW-1:0]    num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= (NumW+1)'(num_i >> QW);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      tag_q[0] <= tag_i;
      num_q[0] <= num_i << (NumW - QW);
      for (int s = 0; s < QW; s++) begin
        logic [NumW+1:0] trial;
        trial = {rem_q[s], num_q[s][NumW-1]};
        if (trial >= {2'b00, den_q[s]}) begin
          rem_q[s+1] <= (NumW+1)'(trial - {2'b00, den_q[s]});
          quo_q[s+1] <= {quo_q[s][QW-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= trial[NumW:0];
          quo_q[s+1] <= {quo_q[s][QW-2:0], 1'b0};
        end
        num_q[s+1] <= {num_q[s][NumW-2:0], 1'b0};
        den_q[s+1] <= den_q[s];
        tag_q[s+1] <= tag_q[s];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quo_o   = quo_q[QW];
  assign tag_o   = tag_q[QW];
endmodule
`default_nettype wire

[src/rgb_to_color_temperature.sv]
// rgb_to_color_temperature: rgb to illuminance and mccamy color temperature pipeline
`timescale 1ns / 1ps
`default_nettype none
// One RGB beat in, one result beat out, one beat per cycle sustained while the
// output is taken. The pipe has FRAC_BITS + 14 register stages: two matrix
// stages, two stages forming the ratio terms, FRAC_BITS + 5 stages of the
// bit-per-stage divider (input register plus four integer bits and the fraction)
// and five for the Horner cubic and saturation. The whole pipe advances together
// and freezes when the output register holds a beat that is not taken; the input
// is ready whenever the output slot is empty or being emptied.
module rgb_to_color_temperature #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rgbcct_if.sink    in_i,
  rgbcct_if.source  out_o
);
  import rgbcct_pkg::*;

  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned QW   = F + 4;          // n integer 0..8 needs 4 bits
  localparam int unsigned MW   = 24 + F + 2;     // X,Y,Z products
  localparam int unsigned SW   = MW + 2;
  localparam int unsigned NW   = SW + 18;        // num, den magnitudes
  localparam int unsigned PW   = 2 * F + 18;     // Horner working width
  localparam int unsigned AMW  = F + 17;         // |p| fed to a product stays below 2^(F+16)
  localparam int unsigned BMW  = F + 4;          // |n| is at most 8
  localparam longint unsigned Scl = 64'd1 << F;

  // round(c * 2^F) from units of 1e-5, halves away from zero
  function automatic longint signed qc(input longint signed s);
    longint unsigned m;
    m = (((s < 0) ? longint'(-s) : s) * Scl + 64'd50000) / 64'd100000;
    return (s < 0) ? -longint'(m) : longint'(m);
  endfunction

  localparam longint signed KXR = qc(-14282);
  localparam longint signed KXG = qc(154924);
  localparam longint signed KXB = qc(-95641);
  localparam longint signed KYR = qc(-32466);
  localparam longint signed KYG = qc(157837);
  localparam longint signed KYB = qc(-73191);
  localparam longint signed KZR = qc(-68202);
  localparam longint signed KZG = qc(77073);
  localparam longint signed KZB = qc(56332);
  localparam longint signed KP3 = qc(44900000);
  localparam longint signed KP2 = qc(352500000);
  localparam longint signed KP1 = qc(682330000);
  localparam longint signed KP0 = qc(552033000);

  logic en;
  logic out_vld_q;
  cct_t out_q;
  assign en       = !out_vld_q || out_o.ready;
  assign in_i.ready = en;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  rgb_t pix;
  assign pix = rgb_t'(in_i.data);

  // stage 1: nine products
  logic s1_q;
  logic signed [MW-1:0] p_q [9];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_q <= 1'b0;
    else if (en) s1_q <= in_i.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= MW'(KXR * $signed({1'b0, pix.red}));
      p_q[1] <= MW'(KXG * $signed({1'b0, pix.green}));
      p_q[2] <= MW'(KXB * $signed({1'b0, pix.blue}));
      p_q[3] <= MW'(KYR * $signed({1'b0, pix.red}));
      p_q[4] <= MW'(KYG * $signed({1'b0, pix.green}));
      p_q[5] <= MW'(KYB * $signed({1'b0, pix.blue}));
      p_q[6] <= MW'(KZR * $signed({1'b0, pix.red}));
      p_q[7] <= MW'(KZG * $signed({1'b0, pix.green}));
      p_q[8] <= MW'(KZB * $signed({1'b0, pix.blue}));
    end
  end

  // stage 2: X, Y, S
  logic s2_q;
  logic signed [SW-1:0] x_q, y_q, s_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_q <= 1'b0;
    else if (en) s2_q <= s1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= SW'(p_q[0]) + SW'(p_q[1]) + SW'(p_q[2]);
      y_q <= SW'(p_q[3]) + SW'(p_q[4]) + SW'(p_q[5]);
      s_q <= SW'(p_q[0]) + SW'(p_q[1]) + SW'(p_q[2]) + SW'(p_q[3]) + SW'(p_q[4])
           + SW'(p_q[5]) + SW'(p_q[6]) + SW'(p_q[7]) + SW'(p_q[8]);
    end
  end

  // stage 3: scaled terms
  logic s3_q;
  logic signed [NW:0] ax_q, as_q, bs_q, by_q;
  logic signed [SW-1:0] y3_q;
  logic sz3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_q <= 1'b0;
    else if (en) s3_q <= s2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q  <= (NW+1)'(x_q) * (NW+1)'(100000);
      as_q  <= (NW+1)'(s_q) * (NW+1)'(33200);
      bs_q  <= (NW+1)'(s_q) * (NW+1)'(18580);
      by_q  <= (NW+1)'(y_q) * (NW+1)'(100000);
      y3_q  <= y_q;
      sz3_q <= (s_q == '0);
    end
  end

  // stage 4: num, den magnitudes, sign, flags
  logic s4_q;
  logic [NW-1:0] un_q, ud_q;
  logic neg4_q, und4_q;
  logic signed [SW-1:0] y4_q;
  logic signed [NW:0] num_c, den_c;
  assign num_c = ax_q - as_q;
  assign den_c = bs_q - by_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_q <= 1'b0;
    else if (en) s4_q <= s3_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      un_q   <= num_c[NW] ? NW'(-num_c) : NW'(num_c);
      ud_q   <= den_c[NW] ? NW'(-den_c) : NW'(den_c);
      neg4_q <= num_c[NW] ^ den_c[NW];
      und4_q <= sz3_q || (den_c == '0);
      y4_q   <= y3_q;
    end
  end

  // divider: quotient of un * 2^F by ud, QW bits, saturating via overflow test
  localparam int unsigned TagW = SW + 2;
  localparam int unsigned DW   = NW + F;
  logic           dv_vld;
  logic [QW-1:0]  dv_quo;
  logic [TagW-1:0] dv_tag;
  logic [DW-1:0]  dv_num;
  logic           big4;
  // integer quotient >= 8 <=> un >= 8*ud; handled by flag, divider gets sane input
  assign big4   = ({3'b000, un_q} >= {ud_q, 3'b000});
  assign dv_num = big4 ? '0 : {un_q, F'(0)};

  rgbcct_div #(.NumW(DW), .QW(QW), .TagW(TagW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_q),
    .num_i   (dv_num),
    .den_i   (DW'(ud_q) | DW'(und4_q)),
    .tag_i   ({y4_q, neg4_q, und4_q}),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .tag_o   (dv_tag)
  );

  // big flag travels alongside the divider
  logic [QW:0] big_q;
  always_ff @(posedge clk_i) begin
    if (en) big_q <= {big_q[QW-1:0], big4};
  end

  // stage a: signed n, then Horner
  logic h0_q;
  logic signed [PW-1:0] n0_q;
  logic signed [SW-1:0] yh0_q;
  logic und_h0_q;
  logic [QW-1:0] nm;
  assign nm = big_q[QW] ? QW'(NClamp << F) : dv_quo;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) h0_q <= 1'b0;
    else if (en) h0_q <= dv_vld;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      n0_q     <= dv_tag[1] ? -PW'(nm) : PW'(nm);
      yh0_q    <= dv_tag[TagW-1:2];
      und_h0_q <= dv_tag[0];
    end
  end

  function automatic logic signed [PW-1:0] qmul(input logic signed [PW-1:0] a,
                                                input logic signed [PW-1:0] b);
    logic [AMW+BMW-1:0] m;
    logic [PW-1:0] ua, ub;
    ua = a[PW-1] ? -a : a;
    ub = b[PW-1] ? -b : b;
    m  = ua[AMW-1:0] * ub[BMW-1:0];
    return (a[PW-1] ^ b[PW-1]) ? -PW'(m >> F) : PW'(m >> F);
  endfunction

  logic h1_q, h2_q, h3_q;
  logic signed [PW-1:0] n1_q, n2_q, p1_q, p2_q, p3_q;
  logic signed [SW-1:0] yh1_q, yh2_q, yh3_q;
  logic und1_q, und2_q, und3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_q <= 1'b0; h2_q <= 1'b0; h3_q <= 1'b0;
    end else if (en) begin
      h1_q <= h0_q; h2_q <= h1_q; h3_q <= h2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= qmul(PW'(KP3), n0_q) + PW'(KP2);
      n1_q <= n0_q; yh1_q <= yh0_q; und1_q <= und_h0_q;
      p2_q <= qmul(p1_q, n1_q) + PW'(KP1);
      n2_q <= n1_q; yh2_q <= yh1_q; und2_q <= und1_q;
      p3_q <= qmul(p2_q, n2_q) + PW'(KP0);
      yh3_q <= yh2_q; und3_q <= und2_q;
    end
  end

  // final: saturate both outputs
  logic [PW-1:0] pm;
  logic [SW-1:0] ym;
  logic [15:0] ct, lx;
  logic ccl, lcl;
  always_comb begin
    pm  = p3_q[PW-1] ? -p3_q : p3_q;
    ym  = yh3_q[SW-1] ? -yh3_q : yh3_q;
    pm  = pm >> F;
    ym  = ym >> F;
    ct  = 16'(pm);
    lx  = 16'(ym);
    ccl = 1'b0;
    lcl = 1'b0;
    if (p3_q[PW-1] && pm != '0) begin ct = '0; ccl = 1'b1; end
    else if (pm > PW'(65535)) begin ct = 16'hFFFF; ccl = 1'b1; end
    if (yh3_q[SW-1] && ym != '0) begin lx = '0; lcl = 1'b1; end
    else if (ym > SW'(65535)) begin lx = 16'hFFFF; lcl = 1'b1; end
    if (und3_q) begin ct = '0; ccl = 1'b0; end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= h3_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.color_temp     <= ct;
      out_q.illuminance    <= lx;
      out_q.undefined_flag <= und3_q;
      out_q.clamped_flag   <= ccl | lcl;
    end
  end
endmodule
`default_nettype wire

[src/rgbcct_chk.sv]
// rgbcct_props: port-level checks for the rgb to color temperature block
`timescale 1ns / 1ps
`default_nettype none
module rgbcct_props (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [33:0] out_data_i
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input not ready with a free output slot");
  a_undef_ct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i[1] |-> out_data_i[33:18] == 16'd0)
    else $error("undefined result with nonzero temperature");
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !$isunknown(out_data_i))
    else $error("result beat carries unknown bits");
endmodule

bind rgb_to_color_temperature rgbcct_props u_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data[33:0])
);
`default_nettype wire

[tb/rgbcct_chk.sv]
// rgbcct_chk: watches both channels, predicts each result and compares field by field
`timescale 1ns / 1ps
module rgbcct_chk
  import rgbcct_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic   clk_i,
  input logic   rst_ni,
  rgbcct_if     in_i,
  rgbcct_if     out_i,
  output int    errors_o,
  output int    pending_o
);

  cct_t expected_q[$];

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint to_q(longint scaled);
    longint m;
    m = ((abs64(scaled) <<< FRAC_BITS) + 50000) / 100000;
    return scaled < 0 ? -m : m;
  endfunction

  function automatic longint mul_q(longint a, longint b);
    longint m;
    m = (abs64(a) * abs64(b)) >>> FRAC_BITS;
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic logic [15:0] sat_u16(longint q, inout logic cl);
    longint m;
    m = abs64(q) >>> FRAC_BITS;
    if (q < 0 && m != 0) begin
      cl = 1'b1;
      return 16'd0;
    end
    if (m > 65535) begin
      cl = 1'b1;
      return 16'hffff;
    end
    return m[15:0];
  endfunction

  function automatic cct_t predict_cct(rgb_t px);
    cct_t res;
    longint r, g, b, x, y, z, s, num, den, n, p;
    logic [127:0] un, ud, nm;
    logic cl;
    r = px.red;
    g = px.green;
    b = px.blue;
    cl = 1'b0;
    x = to_q(-14282) * r + to_q(154924) * g + to_q(-95641) * b;
    y = to_q(-32466) * r + to_q(157837) * g + to_q(-73191) * b;
    z = to_q(-68202) * r + to_q(77073) * g + to_q(56332) * b;
    s = x + y + z;
    num = 100000 * x - 33200 * s;
    den = 18580 * s - 100000 * y;
    res.illuminance = sat_u16(y, cl);
    res.color_temp = '0;
    res.undefined_flag = 1'b0;
    if (s == 0 || den == 0) begin
      res.undefined_flag = 1'b1;
    end else begin
      un = abs64(num);
      ud = abs64(den);
      if (un / ud >= NClamp) nm = 128'(NClamp) << FRAC_BITS;
      else nm = (un << FRAC_BITS) / ud;
      n = ((num < 0) != (den < 0)) ? -longint'(nm) : longint'(nm);
      p = mul_q(to_q(44900000), n) + to_q(352500000);
      p = mul_q(p, n) + to_q(682330000);
      p = mul_q(p, n) + to_q(552033000);
      res.color_temp = sat_u16(p, cl);
    end
    res.clamped_flag = cl;
    return res;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i) begin
    cct_t exp_r, got;
    if (!rst_ni) begin
      errors_o = 0;
    end else begin
      if (in_i.valid && in_i.ready) expected_q.push_back(predict_cct(rgb_t'(in_i.data)));
      if (out_i.valid && out_i.ready) begin
        got = cct_t'(out_i.data);
        if (expected_q.size() == 0) begin
          $error("unexpected result beat %h", got);
          errors_o++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.color_temp !== exp_r.color_temp) begin
            $error("color_temp expected %0d actual %0d", exp_r.color_temp, got.color_temp);
            errors_o++;
          end
          if (got.illuminance !== exp_r.illuminance) begin
            $error("illuminance expected %0d actual %0d", exp_r.illuminance, got.illuminance);
            errors_o++;
          end
          if (got.undefined_flag !== exp_r.undefined_flag) begin
            $error("undefined_flag expected %0b actual %0b", exp_r.undefined_flag,
                   got.undefined_flag);
            errors_o++;
          end
          if (got.clamped_flag !== exp_r.clamped_flag) begin
            $error("clamped_flag expected %0b actual %0b", exp_r.clamped_flag,
                   got.clamped_flag);
            errors_o++;
          end
        end
      end
    end
  end

endmodule

[tb/tb.sv]
// tb: stimulus, handshake pacing and verdict for rgb_to_color_temperature
`timescale 1ns / 1ps
module tb;
  import rgbcct_pkg::*;

  localparam int WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors, pending, idle_cycles;
  int   send_idle_pct, recv_idle_pct;

  rgbcct_if #(.PayloadW($bits(rgb_t))) in_ch ();
  rgbcct_if #(.PayloadW($bits(cct_t))) out_ch ();

  rgb_to_color_temperature #(.FRAC_BITS(16)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  rgbcct_chk #(.FRAC_BITS(16)) u_chk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_ch),
    .out_i    (out_ch),
    .errors_o (errors),
    .pending_o(pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_rgb(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    rgb_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= px;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_random();
    int kind;
    kind = $urandom_range(3);
    case (kind)
      0: send_rgb(16'($urandom), 16'($urandom), 16'($urandom));
      1: send_rgb(16'($urandom_range(255)), 16'($urandom_range(255)),
                  16'($urandom_range(255)));
      2: begin
        logic [15:0] base;
        base = 16'($urandom);
        send_rgb(16'(base + $urandom_range(64)), 16'(base + $urandom_range(64)), base);
      end
      default: send_rgb(16'($urandom_range(4095) << $urandom_range(4)),
                        16'($urandom_range(4095) << $urandom_range(4)),
                        16'($urandom_range(4095) << $urandom_range(4)));
    endcase
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, single channels, channel pairs, mixes, zero sum
    send_rgb(16'h0000, 16'h0000, 16'h0000);
    send_rgb(16'hffff, 16'hffff, 16'hffff);
    send_rgb(16'hffff, 16'h0000, 16'h0000);
    send_rgb(16'h0000, 16'hffff, 16'h0000);
    send_rgb(16'h0000, 16'h0000, 16'hffff);
    send_rgb(16'hffff, 16'hffff, 16'h0000);
    send_rgb(16'hffff, 16'h0000, 16'hffff);
    send_rgb(16'h0000, 16'hffff, 16'hffff);
    send_rgb(16'h0001, 16'h0000, 16'h0000);
    send_rgb(16'h0000, 16'h0001, 16'h0000);
    send_rgb(16'h0000, 16'h0000, 16'h0001);
    send_rgb(16'h0001, 16'h0001, 16'h0001);
    send_rgb(16'h1000, 16'h1000, 16'h1000);
    send_rgb(16'h0100, 16'h0200, 16'h0080);
    send_rgb(16'h0200, 16'h0100, 16'h0040);
    send_rgb(16'h0040, 16'h0100, 16'h0300);
    send_rgb(16'haaaa, 16'h5555, 16'haaaa);
    send_rgb(16'h5555, 16'haaaa, 16'h5555);
    send_rgb(16'h8000, 16'h8000, 16'h8000);

    send_idle_pct = 30;
    recv_idle_pct = 60;
    repeat (600) send_random();

    // hold off until the pipe drains
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    send_idle_pct = 60;
    recv_idle_pct = 30;
    repeat (600) send_random();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (630) send_random();
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
